// File: rtl/tic_pkg.sv
// Package for the two-input control function: opcodes, microcode words and program ROM.
`default_nettype none

package tic_pkg;

  localparam int UAW = 5;
  localparam logic signed [10:0] LEAK_Q16 = 11'sd655;

  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_SUM   = 4'd1;
  localparam logic [3:0] OP_DIFF  = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_AVG   = 4'd4;
  localparam logic [3:0] OP_HAB   = 4'd5;
  localparam logic [3:0] OP_QUANT = 4'd6;
  localparam logic [3:0] OP_LPF   = 4'd7;
  localparam logic [3:0] OP_SMP   = 4'd8;
  localparam logic [3:0] OP_TRK   = 4'd9;
  localparam logic [3:0] OP_OR    = 4'd10;
  localparam logic [3:0] OP_MAX   = 4'd11;
  localparam logic [3:0] OP_MIN   = 4'd12;
  localparam logic [3:0] OP_WGT   = 4'd13;
  localparam logic [3:0] OP_ABSD  = 4'd14;

  typedef enum logic [4:0] {
    UO_ZERO, UO_ADD, UO_SUB, UO_MUL, UO_RND, UO_AVG, UO_HAB,
    UO_QMAG, UO_QSTP, UO_QCLB, UO_QBS, UO_QKT,
    UO_WDV3, UO_DLDS, UO_DSTEP, UO_DOUT, UO_CLIP,
    UO_LPD, UO_LPM, UO_LPU, UO_LPO,
    UO_SMP, UO_TRK, UO_OR, UO_MAX, UO_MIN, UO_WSUM, UO_ABSD,
    UO_CLR, UO_SAT
  } uop_t;

  typedef enum logic [1:0] {JK_NEXT, JK_GOTO, JK_MAGONE, JK_DLOOP} jmp_t;

  typedef struct packed {
    uop_t           uop;
    jmp_t           jmp;
    logic [UAW-1:0] tgt;
    logic           last;
  } ucw_t;

  localparam logic [UAW-1:0] ADR_SAT   = 5'd0;
  localparam logic [UAW-1:0] ADR_ZERO  = 5'd1;
  localparam logic [UAW-1:0] ADR_ADD   = 5'd2;
  localparam logic [UAW-1:0] ADR_SUB   = 5'd3;
  localparam logic [UAW-1:0] ADR_MUL   = 5'd4;
  localparam logic [UAW-1:0] ADR_AVG   = 5'd6;
  localparam logic [UAW-1:0] ADR_HAB   = 5'd7;
  localparam logic [UAW-1:0] ADR_QNT   = 5'd8;
  localparam logic [UAW-1:0] ADR_QDIV  = 5'd13;
  localparam logic [UAW-1:0] ADR_QCLB  = 5'd16;
  localparam logic [UAW-1:0] ADR_LPF   = 5'd17;
  localparam logic [UAW-1:0] ADR_SMP   = 5'd21;
  localparam logic [UAW-1:0] ADR_TRK   = 5'd22;
  localparam logic [UAW-1:0] ADR_OR    = 5'd23;
  localparam logic [UAW-1:0] ADR_MAX   = 5'd24;
  localparam logic [UAW-1:0] ADR_MIN   = 5'd25;
  localparam logic [UAW-1:0] ADR_WGT   = 5'd26;
  localparam logic [UAW-1:0] ADR_ABSD  = 5'd30;
  localparam logic [UAW-1:0] ADR_CLR   = 5'd31;

  function automatic ucw_t ucode(input logic [UAW-1:0] adr);
    ucw_t w;
    w = '{uop: UO_ZERO, jmp: JK_GOTO, tgt: ADR_SAT, last: 1'b0};
    case (adr)
      5'd0:  w = '{uop: UO_SAT,   jmp: JK_NEXT,   tgt: ADR_SAT,  last: 1'b1};
      5'd1:  w = '{uop: UO_ZERO,  jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd2:  w = '{uop: UO_ADD,   jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd3:  w = '{uop: UO_SUB,   jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd4:  w = '{uop: UO_MUL,   jmp: JK_NEXT,   tgt: ADR_SAT,  last: 1'b0};
      5'd5:  w = '{uop: UO_RND,   jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd6:  w = '{uop: UO_AVG,   jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd7:  w = '{uop: UO_HAB,   jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd8:  w = '{uop: UO_QMAG,  jmp: JK_NEXT,   tgt: ADR_SAT,  last: 1'b0};
      5'd9:  w = '{uop: UO_QSTP,  jmp: JK_MAGONE, tgt: ADR_QCLB, last: 1'b0};
      5'd10: w = '{uop: UO_QBS,   jmp: JK_NEXT,   tgt: ADR_SAT,  last: 1'b0};
      5'd11: w = '{uop: UO_QKT,   jmp: JK_NEXT,   tgt: ADR_SAT,  last: 1'b0};
      5'd12: w = '{uop: UO_DLDS,  jmp: JK_NEXT,   tgt: ADR_SAT,  last: 1'b0};
      5'd13: w = '{uop: UO_DSTEP, jmp: JK_DLOOP,  tgt: ADR_QDIV, last: 1'b0};
      5'd14: w = '{uop: UO_DOUT,  jmp: JK_NEXT,   tgt: ADR_SAT,  last: 1'b0};
      5'd15: w = '{uop: UO_CLIP,  jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd16: w = '{uop: UO_QCLB,  jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd17: w = '{uop: UO_LPD,   jmp: JK_NEXT,   tgt: ADR_SAT,  last: 1'b0};
      5'd18: w = '{uop: UO_LPM,   jmp: JK_NEXT,   tgt: ADR_SAT,  last: 1'b0};
      5'd19: w = '{uop: UO_LPU,   jmp: JK_NEXT,   tgt: ADR_SAT,  last: 1'b0};
      5'd20: w = '{uop: UO_LPO,   jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd21: w = '{uop: UO_SMP,   jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd22: w = '{uop: UO_TRK,   jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd23: w = '{uop: UO_OR,    jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd24: w = '{uop: UO_MAX,   jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd25: w = '{uop: UO_MIN,   jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd26: w = '{uop: UO_WSUM,  jmp: JK_NEXT,   tgt: ADR_SAT,  last: 1'b0};
      5'd27: w = '{uop: UO_WDV3,  jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd30: w = '{uop: UO_ABSD,  jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      5'd31: w = '{uop: UO_CLR,   jmp: JK_GOTO,   tgt: ADR_SAT,  last: 1'b0};
      default: w = '{uop: UO_ZERO, jmp: JK_GOTO, tgt: ADR_SAT, last: 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [UAW-1:0] entry(input logic restart, input logic [3:0] op);
    logic [UAW-1:0] e;
    e = ADR_ZERO;
    if (restart) begin
      e = ADR_CLR;
    end else begin
      case (op)
        OP_NONE:  e = ADR_ZERO;
        OP_SUM:   e = ADR_ADD;
        OP_DIFF:  e = ADR_SUB;
        OP_MUL:   e = ADR_MUL;
        OP_AVG:   e = ADR_AVG;
        OP_HAB:   e = ADR_HAB;
        OP_QUANT: e = ADR_QNT;
        OP_LPF:   e = ADR_LPF;
        OP_SMP:   e = ADR_SMP;
        OP_TRK:   e = ADR_TRK;
        OP_OR:    e = ADR_OR;
        OP_MAX:   e = ADR_MAX;
        OP_MIN:   e = ADR_MIN;
        OP_WGT:   e = ADR_WGT;
        OP_ABSD:  e = ADR_ABSD;
        default:  e = ADR_ZERO;
      endcase
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// File: rtl/two_input_control_function.sv
// Two-input control function: microcoded sequencer over a small fixed-point datapath.
// Quantize skips the divide when |a| is one, else runs a radix-2 divider by the step count,
// one bit/cycle. One item at a time: input stalls while the sequencer is busy; the next
// input is taken while a result waits, but the final microstep holds until the output is free.
// Synchronous active-low reset clears operation, filter level, held sample and gate.
`default_nettype none

module two_input_control_function import tic_pkg::*; #(
  parameter int SIGNAL_WIDTH = 16,
  parameter int FILTER_WIDTH = 24
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           in_action,
  input  wire signed [SIGNAL_WIDTH-1:0] in_a_value,
  input  wire signed [SIGNAL_WIDTH-1:0] in_b_value,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic signed [SIGNAL_WIDTH-1:0] out_result_value,
  input  wire                           cfg_wr_en,
  input  wire [3:0]                     cfg_wr_data
);

  localparam int W   = SIGNAL_WIDTH;
  localparam int FW  = FILTER_WIDTH;
  localparam int XW  = (2 * W + 2 > FW + 12) ? 2 * W + 2 : FW + 12;
  localparam int DVW = W + 4;
  localparam int CW  = $clog2(DVW + 1);
  localparam int F   = W - 2;
  localparam int UP  = (FW > W) ? FW - W : 0;
  localparam int DN  = (W > FW) ? W - FW : 0;
  localparam int UPM = (UP > 0) ? UP - 1 : 0;
  localparam int DNM = (DN > 0) ? DN - 1 : 0;
  localparam int MW  = W + 1;
  localparam int RK  = W + 2;
  localparam longint R3_L = ((longint'(1) << RK) + 2) / 3;

  localparam logic signed [XW-1:0] ONE_X   = {{(XW-1){1'b0}}, 1'b1} << F;
  localparam logic signed [XW-1:0] HALF_X  = {{(XW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic signed [XW-1:0] NONE_X  = -ONE_X;
  localparam logic signed [XW-1:0] SMAX_X  = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] SMIN_X  = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] QMASK_X = {{(XW-F){1'b1}}, {F{1'b0}}};
  localparam logic signed [XW-1:0] LPRND_X = {{(XW-16){1'b0}}, 1'b1, 15'b0};
  localparam logic signed [XW-1:0] TFRND_X =
    (DN > 0) ? ({{(XW-1){1'b0}}, 1'b1} << DNM) : '0;
  localparam logic signed [XW-1:0] FFRND_X =
    (UP > 0) ? ({{(XW-1){1'b0}}, 1'b1} << UPM) : '0;
  localparam logic signed [W-1:0]  ONE_W   = {{(W-1){1'b0}}, 1'b1} << F;
  localparam logic signed [W-1:0]  HALF_W  = {{(W-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic signed [W-1:0]  NONE_W  = -ONE_W;
  localparam logic [CW-1:0]        DCNT    = CW'(DVW);
  localparam logic [CW-1:0]        DLAST   = CW'(1);
  // ceil(2^RK / 3): exact truncating divide by three for magnitudes below 2^(W+1)
  localparam logic [MW-1:0]        RECIP3  = MW'(R3_L);

  logic                  busy_r;
  logic [UAW-1:0]        upc_r, upc_nxt;
  logic [3:0]            op_r;
  logic                  out_valid_r;
  logic signed [W-1:0]   out_value_r;
  logic signed [FW-1:0]  level_r, level_nxt;
  logic signed [W-1:0]   held_r, held_nxt;
  logic signed [W-1:0]   pg_r, pg_nxt;

  logic signed [W-1:0]   a_r, b_r;
  logic signed [XW-1:0]  x_r, x_nxt;
  logic [4:0]            s_r, s_nxt;
  logic [DVW-1:0]        quo_r, quo_nxt;
  logic [4:0]            rem_r, rem_nxt;
  logic [4:0]            dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;

  ucw_t                  cw;
  logic                  out_free, step_en, accept, a_one, gate_hi, b_hi;
  logic signed [XW-1:0]  ax, bx, lx, tf, ff, xabs, qx, lpinc, sat_x, w3x;
  logic signed [2*W-1:0] ab_prod;
  logic signed [W+5:0]   bs_prod;
  logic [5:0]            dtry;
  logic [2*MW-1:0]       w3_prod;
  logic [W-1:0]          w3q;

  assign cw       = ucode(upc_r);
  assign out_free = !out_valid_r || !out_stall;
  assign step_en  = !cw.last || out_free;
  assign accept   = in_valid && !busy_r;
  assign in_stall = busy_r;
  assign out_valid = out_valid_r;
  assign out_result_value = out_value_r;

  assign ax      = XW'(a_r);
  assign bx      = XW'(b_r);
  assign lx      = XW'(level_r);
  assign a_one   = (a_r == ONE_W) || (a_r == NONE_W);
  assign gate_hi = a_r > HALF_W;
  assign b_hi    = b_r > HALF_W;
  assign ab_prod = a_r * b_r;
  assign bs_prod = b_r * $signed({1'b0, s_r});
  assign tf      = ((bx <<< UP) + TFRND_X) >>> DN;
  assign ff      = ((lx + FFRND_X) >>> UP) <<< DN;
  assign xabs    = x_r[XW-1] ? -x_r : x_r;
  assign qx      = $signed({{(XW-DVW){1'b0}}, quo_r});
  assign lpinc   = (x_r + LPRND_X) >>> 16;
  assign dtry    = {rem_r, quo_r[DVW-1]};
  assign sat_x   = (x_r > SMAX_X) ? SMAX_X : ((x_r < SMIN_X) ? SMIN_X : x_r);
  assign w3_prod = xabs[MW-1:0] * RECIP3;
  assign w3q     = w3_prod[2*MW-1:RK];
  assign w3x     = $signed({{(XW-W){1'b0}}, w3q});

  always_comb begin
    case (cw.jmp)
      JK_GOTO:   upc_nxt = cw.tgt;
      JK_MAGONE: upc_nxt = a_one ? cw.tgt : upc_r + 1'b1;
      JK_DLOOP:  upc_nxt = (cnt_r != DLAST) ? cw.tgt : upc_r + 1'b1;
      default:   upc_nxt = upc_r + 1'b1;
    endcase
  end

  always_comb begin
    x_nxt     = x_r;
    s_nxt     = s_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    level_nxt = level_r;
    held_nxt  = held_r;
    pg_nxt    = pg_r;
    case (cw.uop)
      UO_ZERO: x_nxt = '0;
      UO_ADD:  x_nxt = ax + bx;
      UO_SUB:  x_nxt = ax - bx;
      UO_MUL:  x_nxt = XW'(ab_prod);
      UO_RND:  x_nxt = (x_r + HALF_X) >>> F;
      UO_AVG:  x_nxt = (ax + bx) >>> 1;
      UO_HAB:  x_nxt = (ax >>> 1) + bx;
      UO_QMAG: x_nxt = ax[XW-1] ? ((-ax) <<< 4) + ax : (ax <<< 4) - ax;
      UO_QSTP: s_nxt = x_r[F+4:F] + 5'd1;
      UO_QCLB: x_nxt = (bx > ONE_X) ? ONE_X : ((bx < NONE_X) ? NONE_X : bx);
      UO_QBS:  x_nxt = XW'(bs_prod);
      UO_QKT:  x_nxt = x_r[XW-1] ? -((-x_r) & QMASK_X) : (x_r & QMASK_X);
      UO_WDV3: x_nxt = x_r[XW-1] ? -w3x : w3x;
      UO_DLDS: begin
        quo_nxt = xabs[DVW-1:0];
        rem_nxt = '0;
        dvs_nxt = s_r;
        neg_nxt = x_r[XW-1];
        cnt_nxt = DCNT;
      end
      UO_DSTEP: begin
        cnt_nxt = cnt_r - 1'b1;
        if (dtry >= {1'b0, dvs_r}) begin
          rem_nxt = 5'(dtry - {1'b0, dvs_r});
          quo_nxt = {quo_r[DVW-2:0], 1'b1};
        end else begin
          rem_nxt = dtry[4:0];
          quo_nxt = {quo_r[DVW-2:0], 1'b0};
        end
      end
      UO_DOUT: x_nxt = neg_r ? -qx : qx;
      UO_CLIP: x_nxt = (x_r > ONE_X) ? ONE_X : ((x_r < NONE_X) ? NONE_X : x_r);
      UO_LPD:  x_nxt = tf - lx;
      UO_LPM:  x_nxt = XW'(x_r * LEAK_Q16);
      UO_LPU:  level_nxt = level_r + lpinc[FW-1:0];
      UO_LPO:  x_nxt = ff;
      UO_SMP: begin
        held_nxt = (gate_hi && (pg_r < HALF_W)) ? b_r : held_r;
        pg_nxt   = a_r;
        x_nxt    = XW'(held_nxt);
      end
      UO_TRK: begin
        held_nxt = gate_hi ? b_r : held_r;
        x_nxt    = XW'(held_nxt);
      end
      UO_OR:   x_nxt = (gate_hi || b_hi) ? ONE_X : '0;
      UO_MAX:  x_nxt = (ax > bx) ? ax : bx;
      UO_MIN:  x_nxt = (ax < bx) ? ax : bx;
      UO_WSUM: x_nxt = ax + (bx <<< 1);
      UO_ABSD: x_nxt = (ax > bx) ? ax - bx : bx - ax;
      UO_CLR: begin
        level_nxt = '0;
        held_nxt  = '0;
        pg_nxt    = '0;
        x_nxt     = '0;
      end
      UO_SAT:  x_nxt = x_r;
      default: x_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      upc_r       <= ADR_SAT;
      op_r        <= OP_NONE;
      out_valid_r <= 1'b0;
      level_r     <= '0;
      held_r      <= '0;
      pg_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        op_r <= cfg_wr_data;
      end
      if (busy_r && step_en && cw.last) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        busy_r <= 1'b1;
        upc_r  <= entry(in_action, op_r);
      end else if (busy_r && step_en) begin
        level_r <= level_nxt;
        held_r  <= held_nxt;
        pg_r    <= pg_nxt;
        if (cw.last) begin
          busy_r <= 1'b0;
        end else begin
          upc_r <= upc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r <= in_a_value;
      b_r <= in_b_value;
    end else if (busy_r && step_en) begin
      x_r   <= x_nxt;
      s_r   <= s_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      dvs_r <= dvs_nxt;
      neg_r <= neg_nxt;
      cnt_r <= cnt_nxt;
      if (cw.last) begin
        out_value_r <= sat_x[W-1:0];
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> busy_r)
    else $error("sequencer not started after input transfer");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r && cw.last))
    else $error("result raised outside final microstep");

  a_clr_state: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && upc_r == ADR_CLR) |=> (level_r == '0 && held_r == '0 && pg_r == '0))
    else $error("restart did not clear stored state");

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cw.uop == UO_DSTEP) |-> (cnt_r != '0))
    else $error("divider stepped with empty count");

endmodule

`default_nettype wire

// File: tb/sv/two_input_control_function_tb.sv
// Testbench for two_input_control_function: directed and random transfers checked against a predictor.
`timescale 1ns / 100ps

module two_input_control_function_tb;
  import tic_pkg::*;

  localparam int SW = 16;
  localparam logic [3:0] OP_UNUSED = 4'd15;
  localparam longint UNITY = 64'sd16384;
  localparam longint HALF_UNITY = 64'sd8192;
  localparam longint SIG_HI = 64'sd32767;
  localparam longint SIG_LO = -64'sd32768;
  localparam longint LEAK_COEF = 64'sd655;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = 1'b0;
  logic signed [SW-1:0] in_a_value = '0;
  logic signed [SW-1:0] in_b_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SW-1:0] out_result_value;
  logic cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = '0;

  // predictor state
  logic [3:0] cur_op = OP_NONE;
  longint filt_level = 0;
  longint held_level = 0;
  longint last_gate = 0;

  logic signed [SW-1:0] due_results[$];
  logic signed [SW-1:0] want;
  int fault_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic tx_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;

  two_input_control_function dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_a_value(in_a_value),
    .in_b_value(in_b_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_value(out_result_value),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [SW-1:0] sat_signal(input longint x);
    if (x > SIG_HI) return SW'(SIG_HI);
    if (x < SIG_LO) return SW'(SIG_LO);
    return SW'(x);
  endfunction

  function automatic longint clip_unity(input longint x);
    if (x > UNITY) return UNITY;
    if (x < -UNITY) return -UNITY;
    return x;
  endfunction

  function automatic logic signed [SW-1:0] control_fn(input logic restart,
                                                      input logic signed [SW-1:0] a,
                                                      input logic signed [SW-1:0] b);
    longint av, bv, r, mag, steps, k, d;
    av = a;
    bv = b;
    r = 0;
    if (restart) begin
      filt_level = 0;
      held_level = 0;
      last_gate = 0;
      return '0;
    end
    case (cur_op)
      OP_SUM:  r = av + bv;
      OP_DIFF: r = av - bv;
      OP_MUL:  r = (av * bv + HALF_UNITY) >>> 14;
      OP_AVG:  r = (av + bv) >>> 1;
      OP_HAB:  r = (av >>> 1) + bv;
      OP_QUANT: begin
        mag = (av < 0) ? -av : av;
        steps = (mag * 15) / UNITY + 1;
        if (mag == UNITY) begin
          r = clip_unity(bv);
        end else begin
          k = (bv * steps) / UNITY;
          r = clip_unity((k * UNITY) / steps);
        end
      end
      OP_LPF: begin
        d = bv * 256 - filt_level;
        filt_level = filt_level + ((d * LEAK_COEF + 32768) >>> 16);
        r = (filt_level + 128) >>> 8;
      end
      OP_SMP: begin
        if (av > HALF_UNITY && last_gate < HALF_UNITY) held_level = bv;
        last_gate = av;
        r = held_level;
      end
      OP_TRK: begin
        if (av > HALF_UNITY) held_level = bv;
        r = held_level;
      end
      OP_OR:   r = (av > HALF_UNITY || bv > HALF_UNITY) ? UNITY : 0;
      OP_MAX:  r = (av > bv) ? av : bv;
      OP_MIN:  r = (av < bv) ? av : bv;
      OP_WGT:  r = (av + 2 * bv) / 3;
      OP_ABSD: r = (av > bv) ? av - bv : bv - av;
      default: r = 0;
    endcase
    return sat_signal(r);
  endfunction

  function automatic logic signed [SW-1:0] pick_level();
    longint v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $signed(SW'($urandom));
      3: begin
        case ($urandom_range(0, 5))
          0: v = SIG_LO;
          1: v = SIG_HI;
          2: v = SIG_LO + 1;
          3: v = 0;
          4: v = -1;
          default: v = 1;
        endcase
      end
      4: v = HALF_UNITY + $urandom_range(0, 4) - 2;
      5: v = ($urandom_range(0, 1) ? UNITY : -UNITY) + $urandom_range(0, 4) - 2;
      6: v = longint'($urandom_range(0, 511)) - 256;
      default: v = longint'($urandom_range(0, 32768)) - UNITY;
    endcase
    if ($urandom_range(0, 7) == 0) v = -v;
    return sat_signal(v);
  endfunction

  // one transfer on the input channel; valid is left high for a possible follow-on item
  task automatic send_item(input logic act, input logic signed [SW-1:0] a,
                           input logic signed [SW-1:0] b);
    if (tx_idle_en && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      in_action <= 1'($urandom);
      in_a_value <= SW'($urandom);
      in_b_value <= SW'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_a_value <= a;
    in_b_value <= b;
    do @(posedge clk); while (in_stall);
    due_results.push_back(control_fn(act, a, b));
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_operation(input logic [3:0] op);
    drain_block();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= op;
    @(posedge clk);
    cur_op = op;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(1'b0, 16'sd32767, 16'sd32767);
    set_operation(OP_SUM);
    send_item(1'b0, 16'sd32767, 16'sd32767);
    send_item(1'b0, -16'sd32768, -16'sd32768);
    set_operation(OP_DIFF);
    send_item(1'b0, 16'sd32767, -16'sd32768);
    set_operation(OP_MUL);
    send_item(1'b0, -16'sd32768, -16'sd32768);
    send_item(1'b0, -16'sd3, 16'sd8192);
    set_operation(OP_AVG);
    send_item(1'b0, -16'sd1, 16'sd0);
    set_operation(OP_HAB);
    send_item(1'b0, -16'sd32768, 16'sd32767);
    set_operation(OP_QUANT);
    send_item(1'b0, 16'sd16384, 16'sd20000);
    send_item(1'b0, -16'sd16384, -16'sd20000);
    send_item(1'b0, 16'sd0, 16'sd12000);
    send_item(1'b0, -16'sd32768, 16'sd32767);
    set_operation(OP_LPF);
    send_item(1'b0, 16'sd0, 16'sd32767);
    set_operation(OP_SMP);
    send_item(1'b0, 16'sd16384, 16'sd1000);
    send_item(1'b0, 16'sd8192, 16'sd2000);
    // gate sitting exactly at half blocks the next edge
    send_item(1'b0, 16'sd8193, 16'sd3000);
    send_item(1'b1, 16'sd0, 16'sd0);
    set_operation(OP_TRK);
    send_item(1'b0, 16'sd8193, 16'sd500);
    send_item(1'b0, 16'sd8192, 16'sd600);
    set_operation(OP_OR);
    send_item(1'b0, 16'sd8193, 16'sd0);
    set_operation(OP_MAX);
    send_item(1'b0, -16'sd1, 16'sd0);
    set_operation(OP_MIN);
    send_item(1'b0, -16'sd1, 16'sd0);
    set_operation(OP_WGT);
    send_item(1'b0, 16'sd1, -16'sd1);
    send_item(1'b0, -16'sd32768, -16'sd32768);
    set_operation(OP_ABSD);
    send_item(1'b0, 16'sd32767, -16'sd32768);
    set_operation(OP_UNUSED);
    send_item(1'b0, 16'sd100, 16'sd100);
  endtask

  task automatic test_random_mix(input int phases, input int per_phase);
    logic signed [SW-1:0] a, b;
    logic sticky;
    for (int ph = 0; ph < phases; ph++) begin
      set_operation(ph < 16 ? 4'(ph) : 4'($urandom_range(0, 15)));
      sticky = 1'($urandom_range(0, 1));
      b = pick_level();
      for (int n = 0; n < per_phase; n++) begin
        a = pick_level();
        if (!sticky || $urandom_range(0, 9) == 0) b = pick_level();
        send_item($urandom_range(0, 24) == 0, a, b);
      end
    end
  endtask

  task automatic test_back_to_back();
    tx_idle_en <= 1'b0;
    rx_idle_en <= 1'b0;
    test_random_mix(3, 50);
    drain_block();
    tx_idle_en <= 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  task automatic test_output_hold();
    set_operation(OP_MAX);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int n = 0; n < 40; n++) send_item(1'b0, pick_level(), pick_level());
  endtask

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_req) hold_left <= HOLD_CYCLES;
    out_stall <= (hold_left != 0) || (rx_idle_en && $urandom_range(0, 99) < 10);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        note_fault($sformatf("unexpected result transfer, value %0d", out_result_value));
      end else begin
        want = due_results.pop_front();
        if (out_result_value !== want)
          note_fault($sformatf("result_value mismatch: expected %0d, got %0d",
                               want, out_result_value));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("two_input_control_function_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(24, 60);
    test_back_to_back();
    test_output_hold();
    drain_block();
    if (fault_count == 0 && due_results.size() == 0)
      $display("two_input_control_function_tb: PASS");
    else
      $display("two_input_control_function_tb: FAIL");
    $finish;
  end

endmodule
